FILE: rtl/core/sobel_pkg.sv
// Shared types and constants for the Sobel edge magnitude core.
// Used by the controller, the datapath and the top level; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package sobel_pkg;

	localparam int unsigned ChanW   = 8;
	localparam int unsigned CfgW    = 11;
	localparam int unsigned GradW   = 11;
	localparam int unsigned SqW     = 20;
	localparam int unsigned SumW    = 21;

	// Register indexes on the configuration port.
	localparam logic RegFrameWidth  = 1'b0;
	localparam logic RegFrameHeight = 1'b1;

	// Request codes.
	localparam logic ReqPixel = 1'b0;
	localparam logic ReqFlush = 1'b1;

	typedef logic [ChanW-1:0] chan_t;

	typedef struct packed {
		chan_t red;
		chan_t green;
		chan_t blue;
	} pix_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_GRAD,
		ST_SQUARE,
		ST_ROOT,
		ST_DONE
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;
		logic shift;
		logic grad;
		logic square;
		logic root_step;
		logic out_load;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic emit;
		logic root_last;
		logic out_free;
	} status_t;

endpackage

`default_nettype wire

FILE: rtl/core/sobel_edge_magnitude_rgb_core.sv
// Sobel edge magnitude core, 3x3, per RGB channel: top level.
// Instantiates sobel_ctrl and sobel_datapath; depends on sobel_pkg.
//
// Usage: pixels of one frame enter in row-major order on the input channel
// (in_valid / in_stall), req_type selecting pixel or flush request. The
// result for a frame position comes out on the output channel
// (out_valid / out_stall) once the request width+1 positions later has been
// taken; width+1 flush requests drain the frame, and frame_end marks the
// result for its last pixel. Borders read as zero.
// Sequence: a request that yields no result passes through capture plus
// line store read, then store write and window shift. A request that
// yields a result goes on through gradient, squares, the bit-serial rounded
// root and the output load; out_valid rises once the result is loaded into
// the output register. The next request is taken as soon as the result is
// in the output register, so a stalled receiver holds the core only when a
// second result is ready while the first still waits.
// Reset: sizes return to 640 x 480, position and window clear; the line
// stores need no clearing since the top row is masked. A configuration
// write restarts the frame; a result already in progress still completes.
`timescale 1ns / 1ps
`default_nettype none

module sobel_edge_magnitude_rgb_core #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 1024
) (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         cfg_wr_en,
	input  wire                         cfg_index,
	input  wire [sobel_pkg::CfgW-1:0]   cfg_data,
	input  wire                         in_valid,
	output logic                        in_stall,
	input  wire                         req_type,
	input  wire [sobel_pkg::ChanW-1:0]  pix_red,
	input  wire [sobel_pkg::ChanW-1:0]  pix_green,
	input  wire [sobel_pkg::ChanW-1:0]  pix_blue,
	output logic                        out_valid,
	input  wire                         out_stall,
	output logic [sobel_pkg::ChanW-1:0] edge_red,
	output logic [sobel_pkg::ChanW-1:0] edge_green,
	output logic [sobel_pkg::ChanW-1:0] edge_blue,
	output logic                        frame_end
);
	import sobel_pkg::*;

	cmd_t    cmd;
	status_t status;

	// Sequencer.
	sobel_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.status   (status),
		.cmd      (cmd)
	);

	// Storage and arithmetic.
	sobel_datapath #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.req_type   (req_type),
		.pix_red    (pix_red),
		.pix_green  (pix_green),
		.pix_blue   (pix_blue),
		.cmd        (cmd),
		.status     (status),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.edge_red   (edge_red),
		.edge_green (edge_green),
		.edge_blue  (edge_blue),
		.frame_end  (frame_end)
	);

endmodule

`default_nettype wire

FILE: rtl/core/sobel_ctrl.sv
// Controller state machine for the Sobel edge magnitude core.
// Depends on sobel_pkg for the state, command and status types.
`timescale 1ns / 1ps
`default_nettype none

module sobel_ctrl (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  in_valid,
	output logic                 in_stall,
	input  sobel_pkg::status_t   status,
	output sobel_pkg::cmd_t      cmd
);
	import sobel_pkg::*;

	state_t state_q;
	state_t state_nxt;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Next state logic.
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) state_nxt = ST_READ;
			end
			ST_READ: begin
				state_nxt = status.emit ? ST_GRAD : ST_IDLE;
			end
			ST_GRAD:   state_nxt = ST_SQUARE;
			ST_SQUARE: state_nxt = ST_ROOT;
			ST_ROOT: begin
				if (status.root_last) state_nxt = ST_DONE;
			end
			ST_DONE: begin
				if (status.out_free) state_nxt = ST_IDLE;
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	// Output decode.
	always_comb begin
		cmd      = '0;
		in_stall = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				in_stall    = 1'b0;
				cmd.capture = in_valid;
			end
			ST_READ:   cmd.shift     = 1'b1;
			ST_GRAD:   cmd.grad      = 1'b1;
			ST_SQUARE: cmd.square    = 1'b1;
			ST_ROOT:   cmd.root_step = 1'b1;
			ST_DONE:   cmd.out_load  = status.out_free;
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

endmodule

`default_nettype wire

FILE: rtl/core/sobel_datapath.sv
// Datapath of the Sobel edge magnitude core: position counters, line stores,
// window, gradients, squares, iterative rounded root and output register.
// Depends on sobel_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sobel_datapath #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 1024
) (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         cfg_wr_en,
	input  wire                         cfg_index,
	input  wire [sobel_pkg::CfgW-1:0]   cfg_data,
	input  wire                         req_type,
	input  wire [sobel_pkg::ChanW-1:0]  pix_red,
	input  wire [sobel_pkg::ChanW-1:0]  pix_green,
	input  wire [sobel_pkg::ChanW-1:0]  pix_blue,
	input  sobel_pkg::cmd_t             cmd,
	output sobel_pkg::status_t          status,
	output logic                        out_valid,
	input  wire                         out_stall,
	output logic [sobel_pkg::ChanW-1:0] edge_red,
	output logic [sobel_pkg::ChanW-1:0] edge_green,
	output logic [sobel_pkg::ChanW-1:0] edge_blue,
	output logic                        frame_end
);
	import sobel_pkg::*;

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int WW = $clog2(MAX_WIDTH + 1);
	localparam int HW = $clog2(MAX_HEIGHT + 1);
	localparam int RW = $clog2(MAX_HEIGHT + 2);

	logic [WW-1:0] width_q;
	logic [HW-1:0] height_q;
	logic [CW-1:0] in_col_q;
	logic [RW-1:0] in_row_q;
	logic [CW-1:0] out_col_q;
	logic [HW-1:0] out_row_q;

	pix_t          up_mem  [MAX_WIDTH];
	pix_t          mid_mem [MAX_WIDTH];
	pix_t          up_rd_q;
	pix_t          mid_rd_q;
	pix_t          pix_q;
	logic [CW-1:0] addr_q;
	logic          emit_q;
	logic          fe_q;
	logic          mask_top_q;
	logic          mask_left_q;
	logic          mask_right_q;

	// Window: [row][col], row 0 on top, col 0 on the left.
	pix_t win_q [3][3];

	logic signed [GradW-1:0] gx_q [3];
	logic signed [GradW-1:0] gy_q [3];
	logic        [SumW-1:0]  sum_q [3];
	chan_t                   root_q [3];
	logic        [ChanW-1:0] rbit_q;

	logic          emit;
	logic          last_col;
	logic          fe;
	logic [CW-1:0] nxt_col;
	logic [RW-1:0] nxt_row;
	pix_t          pix_in;
	logic          out_free;

	// Clamp a configured size to the supported range.
	function automatic int unsigned clamp_size(input logic [CfgW-1:0] v,
			input int unsigned max_v);
		int unsigned r;
		r = 32'(v);
		if (v == '0) r = 1;
		else if (r > max_v) r = max_v;
		return r;
	endfunction

	// Position bookkeeping for the request at the input.
	always_comb begin
		emit     = (in_row_q >= RW'(2)) || ((in_row_q == RW'(1)) && (in_col_q != '0));
		fe       = emit && (out_row_q == height_q - HW'(1))
		           && ((WW'(out_col_q) + WW'(1)) == width_q);
		last_col = (WW'(in_col_q) + WW'(1)) == width_q;
		nxt_col  = last_col ? '0 : in_col_q + CW'(1);
		nxt_row  = last_col ? in_row_q + RW'(1) : in_row_q;
		pix_in   = '0;
		if (req_type == ReqPixel && in_row_q < RW'(height_q)) begin
			pix_in = '{red: pix_red, green: pix_green, blue: pix_blue};
		end
	end

	// Configuration registers and frame position counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q   <= WW'(640);
			height_q  <= HW'(480);
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				RegFrameWidth:  width_q  <= WW'(clamp_size(cfg_data, MAX_WIDTH));
				RegFrameHeight: height_q <= HW'(clamp_size(cfg_data, MAX_HEIGHT));
				default: ;
			endcase
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
		end else if (cmd.capture) begin
			if (fe) begin
				in_col_q  <= '0;
				in_row_q  <= '0;
				out_col_q <= '0;
				out_row_q <= '0;
			end else begin
				in_col_q <= nxt_col;
				in_row_q <= nxt_row;
				if (emit) begin
					if ((WW'(out_col_q) + WW'(1)) == width_q) begin
						out_col_q <= '0;
						out_row_q <= out_row_q + HW'(1);
					end else begin
						out_col_q <= out_col_q + CW'(1);
					end
				end
			end
		end
	end

	// Capture of the request, its border masks and the line store reads.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			pix_q        <= pix_in;
			addr_q       <= in_col_q;
			emit_q       <= emit;
			fe_q         <= fe;
			mask_top_q   <= out_row_q == '0;
			mask_left_q  <= out_col_q == '0;
			mask_right_q <= (WW'(out_col_q) + WW'(1)) == width_q;
			up_rd_q      <= up_mem[in_col_q];
			mid_rd_q     <= mid_mem[in_col_q];
		end
	end

	// Line store writes: the middle row moves up, the new pixel enters.
	always_ff @(posedge clk) begin
		if (cmd.shift) begin
			up_mem[addr_q]  <= mid_rd_q;
			mid_mem[addr_q] <= pix_q;
		end
	end

	// Window shift by one column.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < 3; r++) begin
				for (int c = 0; c < 3; c++) begin
					win_q[r][c] <= '0;
				end
			end
		end else if (cmd.shift) begin
			for (int r = 0; r < 3; r++) begin
				win_q[r][0] <= win_q[r][1];
				win_q[r][1] <= win_q[r][2];
			end
			win_q[0][2] <= up_rd_q;
			win_q[1][2] <= mid_rd_q;
			win_q[2][2] <= pix_q;
		end
	end

	// Gradients per channel with border neighbors forced to zero.
	always_ff @(posedge clk) begin
		if (cmd.grad) begin
			for (int ch = 0; ch < 3; ch++) begin
				logic signed [GradW-1:0] p [3][3];
				for (int r = 0; r < 3; r++) begin
					for (int c = 0; c < 3; c++) begin
						logic [ChanW-1:0] v;
						v = (ch == 0) ? win_q[r][c].red :
						    (ch == 1) ? win_q[r][c].green : win_q[r][c].blue;
						if ((r == 0 && mask_top_q) || (c == 0 && mask_left_q)
								|| (c == 2 && mask_right_q)) begin
							v = '0;
						end
						p[r][c] = $signed({{(GradW-ChanW){1'b0}}, v});
					end
				end
				gx_q[ch] <= (p[0][2] + (p[1][2] <<< 1) + p[2][2])
				          - (p[0][0] + (p[1][0] <<< 1) + p[2][0]);
				gy_q[ch] <= (p[2][0] + (p[2][1] <<< 1) + p[2][2])
				          - (p[0][0] + (p[0][1] <<< 1) + p[0][2]);
			end
		end
	end

	// Sum of squares per channel.
	always_ff @(posedge clk) begin
		if (cmd.square) begin
			for (int ch = 0; ch < 3; ch++) begin
				logic signed [2*GradW-1:0] sx;
				logic signed [2*GradW-1:0] sy;
				sx = gx_q[ch] * gx_q[ch];
				sy = gy_q[ch] * gy_q[ch];
				sum_q[ch] <= SumW'(sx[SqW-1:0]) + SumW'(sy[SqW-1:0]);
			end
		end
	end

	// Rounded root, one result bit per cycle from the top: keep the trial
	// bit while n*n - n stays below the sum.
	always_ff @(posedge clk) begin
		if (cmd.square) begin
			rbit_q <= {1'b1, {(ChanW-1){1'b0}}};
			for (int ch = 0; ch < 3; ch++) root_q[ch] <= '0;
		end else if (cmd.root_step) begin
			rbit_q <= rbit_q >> 1;
			for (int ch = 0; ch < 3; ch++) begin
				chan_t             t;
				logic [2*ChanW-1:0] f;
				t = root_q[ch] | rbit_q;
				f = (t * t) - (2*ChanW)'(t);
				if (SumW'(f) < sum_q[ch]) root_q[ch] <= t;
			end
		end
	end

	// Output register.
	assign out_free = !out_valid || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			edge_red   <= root_q[0];
			edge_green <= root_q[1];
			edge_blue  <= root_q[2];
			frame_end  <= fe_q;
		end
	end

	assign status = '{emit: emit_q, root_last: rbit_q[0], out_free: out_free};

endmodule

`default_nettype wire

FILE: verif/tb.sv
// Self-checking testbench for the Sobel edge magnitude core.
// Depends on sobel_pkg and sobel_edge_magnitude_rgb_core; needs no other file.
`timescale 1ns / 1ps

module tb;
	import sobel_pkg::*;

	localparam int MAX_W     = 1024;
	localparam int MAX_H     = 1024;
	localparam int HIST_LEN  = 2 * MAX_W + 3;
	localparam int RAND_REQS = 900;
	localparam int LONG_HOLD = 400;
	localparam int DRAIN_CYC = 30;
	localparam int LIMIT     = 3000000;

	typedef struct {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic       fend;
	} mag_t;

	typedef enum logic {ROW_CFG, ROW_REQ} row_kind_t;

	typedef struct {
		row_kind_t  kind;
		logic       idx;
		logic [10:0] data;
		logic       req;
		pix_t       px;
		logic       typed;
		mag_t       mag;
	} stim_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_wr_en = 1'b0;
	logic        cfg_index = RegFrameWidth;
	logic [10:0] cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic        req_type = ReqPixel;
	logic [7:0]  pix_red = '0;
	logic [7:0]  pix_green = '0;
	logic [7:0]  pix_blue = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [7:0]  edge_red;
	logic [7:0]  edge_green;
	logic [7:0]  edge_blue;
	logic        frame_end;

	// Predictor state: registers, pixel history and input position.
	logic [10:0] width_reg;
	logic [10:0] height_reg;
	logic [23:0] pix_hist [HIST_LEN];
	int unsigned in_col;
	int unsigned in_row;

	mag_t        pending_edges[$];
	stim_row_t   stim_rows[$];
	int          errors = 0;
	int          reqs_sent = 0;
	int          edges_seen = 0;
	int          frames_seen = 0;
	int unsigned cycles = 0;
	bit          quiet_sender = 0;
	bit          quiet_receiver = 0;
	bit          long_hold_go = 0;
	bit          long_hold_done = 0;
	int          hold_cnt = 0;
	int          stall_left = 0;

	sobel_edge_magnitude_rgb_core u_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall), .req_type(req_type),
		.pix_red(pix_red), .pix_green(pix_green), .pix_blue(pix_blue),
		.out_valid(out_valid), .out_stall(out_stall),
		.edge_red(edge_red), .edge_green(edge_green), .edge_blue(edge_blue),
		.frame_end(frame_end)
	);

	always #5 clk = ~clk;

	// Run limit.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	function automatic int unsigned clamp_size(input logic [10:0] v, input int unsigned max);
		if (v == 0)
			return 1;
		if (v > max)
			return max;
		return v;
	endfunction

	// Rounded integer root, saturated at 255.
	function automatic logic [7:0] rounded_root(input int unsigned s);
		int unsigned n;
		n = 0;
		if (s > 255 * 255 + 255)
			return 8'd255;
		while (n * n + n < s)
			n++;
		return n[7:0];
	endfunction

	// Sobel magnitude predictor: takes one request, returns the result it causes.
	task automatic sobel_predict(input logic req, input pix_t px, output logic fired,
			output mag_t mag);
		int unsigned w, h, p, q, r, c;
		int rr, cc, dr, dc, kx, ky, v, k, ch;
		int gx[3];
		int gy[3];
		logic [23:0] nb;
		logic [7:0] m[3];
		w = clamp_size(width_reg, MAX_W);
		h = clamp_size(height_reg, MAX_H);
		p = in_row * w + in_col;
		pix_hist[p % HIST_LEN] = (req == ReqPixel && in_row < h) ? px : 24'd0;
		in_col++;
		if (in_col >= w) begin
			in_col = 0;
			in_row++;
		end
		fired = 1'b0;
		mag = '{default: '0};
		if (p < w + 1)
			return;
		q = p - w - 1;
		r = q / w;
		c = q % w;
		gx = '{0, 0, 0};
		gy = '{0, 0, 0};
		for (k = 0; k < 9; k++) begin
			dr = k / 3 - 1;
			dc = k % 3 - 1;
			rr = int'(r) + dr;
			cc = int'(c) + dc;
			if (rr < 0 || cc < 0 || rr >= int'(h) || cc >= int'(w))
				continue;
			kx = dc * ((dr == 0) ? 2 : 1);
			ky = dr * ((dc == 0) ? 2 : 1);
			nb = pix_hist[(rr * w + cc) % HIST_LEN];
			for (ch = 0; ch < 3; ch++) begin
				v = nb[23 - 8 * ch -: 8];
				gx[ch] += kx * v;
				gy[ch] += ky * v;
			end
		end
		for (ch = 0; ch < 3; ch++)
			m[ch] = rounded_root(gx[ch] * gx[ch] + gy[ch] * gy[ch]);
		fired = 1'b1;
		mag.red = m[0];
		mag.green = m[1];
		mag.blue = m[2];
		mag.fend = (q == w * h - 1);
		if (mag.fend) begin
			in_col = 0;
			in_row = 0;
		end
	endtask

	function automatic int pick_gap(input bit quiet);
		int u;
		u = $urandom_range(99);
		if (quiet || u < 55)
			return 0;
		if (u < 94)
			return $urandom_range(3, 1);
		return $urandom_range(60, 15);
	endfunction

	// Receiver: random stalls, plus one long hold-off while requests keep coming.
	always @(posedge clk) begin
		if (long_hold_go && !long_hold_done) begin
			out_stall <= 1'b1;
			hold_cnt <= hold_cnt + 1;
			if (hold_cnt >= LONG_HOLD)
				long_hold_done <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
		end else if (quiet_receiver) begin
			out_stall <= 1'b0;
		end else begin
			out_stall <= ($urandom_range(99) < 35);
			stall_left <= pick_gap(1'b0);
		end
	end

	// Result check against the oldest expectation.
	always @(posedge clk) begin
		mag_t want;
		if (arst_n && out_valid && !out_stall) begin
			edges_seen <= edges_seen + 1;
			if (frame_end)
				frames_seen <= frames_seen + 1;
			if (pending_edges.size() == 0) begin
				$error("unexpected result: red %0d green %0d blue %0d frame_end %0b",
					edge_red, edge_green, edge_blue, frame_end);
				errors++;
			end else begin
				want = pending_edges.pop_front();
				if (edge_red !== want.red) begin
					$error("edge_red: expected %0d, got %0d", want.red, edge_red);
					errors++;
				end
				if (edge_green !== want.green) begin
					$error("edge_green: expected %0d, got %0d", want.green, edge_green);
					errors++;
				end
				if (edge_blue !== want.blue) begin
					$error("edge_blue: expected %0d, got %0d", want.blue, edge_blue);
					errors++;
				end
				if (frame_end !== want.fend) begin
					$error("frame_end: expected %0b, got %0b", want.fend, frame_end);
					errors++;
				end
			end
		end
	end

	// Offer one request, wait for it to be taken, then record its result.
	task automatic send_request(input logic req, input pix_t px, input bit typed,
			input mag_t typed_mag);
		int gap;
		logic fired;
		mag_t mag;
		gap = pick_gap(quiet_sender);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		req_type <= req;
		{pix_red, pix_green, pix_blue} <= px;
		do
			@(posedge clk);
		while (in_stall);
		reqs_sent++;
		sobel_predict(req, px, fired, mag);
		if (fired)
			pending_edges.push_back(typed ? typed_mag : mag);
	endtask

	// Registers change only once the core has settled.
	task automatic write_reg(input logic idx, input logic [10:0] val);
		in_valid <= 1'b0;
		while (pending_edges.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYC) @(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		if (idx == RegFrameWidth)
			width_reg = val;
		else
			height_reg = val;
		in_col = 0;
		in_row = 0;
	endtask

	function automatic pix_t rand_pix();
		pix_t px;
		px = 24'($urandom);
		if ($urandom_range(9) == 0)
			px = ($urandom_range(1) != 0) ? 24'hFFFFFF : 24'h000000;
		return px;
	endfunction

	// One frame of well-formed requests; noise swaps request types, a cut
	// frame stops early.
	task automatic run_frame(input bit noisy, input bit cut);
		int unsigned w, h, n, i;
		logic req;
		w = clamp_size(width_reg, MAX_W);
		h = clamp_size(height_reg, MAX_H);
		n = w * h + w + 1;
		if (cut)
			n = $urandom_range(n - 1, 1);
		for (i = 0; i < n; i++) begin
			req = (i < w * h) ? ReqPixel : ReqFlush;
			if (noisy && $urandom_range(9) == 0)
				req = ~req;
			send_request(req, rand_pix(), 1'b0, '{default: '0});
		end
	endtask

	function automatic stim_row_t cfg_row(input logic idx, input logic [10:0] val);
		return '{ROW_CFG, idx, val, ReqPixel, '0, 1'b0, '{default: '0}};
	endfunction

	function automatic stim_row_t req_row(input logic req, input pix_t px);
		return '{ROW_REQ, RegFrameWidth, '0, req, px, 1'b0, '{default: '0}};
	endfunction

	initial begin
		stim_row_t row;
		mag_t zero_end;
		int rand_start;
		int phase;
		int frames;
		int f;

		width_reg = 11'd640;
		height_reg = 11'd480;
		in_col = 0;
		in_row = 0;
		foreach (pix_hist[i])
			pix_hist[i] = '0;

		// Directed table.
		zero_end = '{8'd0, 8'd0, 8'd0, 1'b1};
		// Zero sizes are used as a 1x1 frame: the center has no weight.
		stim_rows.push_back(cfg_row(RegFrameWidth, 11'd0));
		stim_rows.push_back(cfg_row(RegFrameHeight, 11'd0));
		stim_rows.push_back(req_row(ReqPixel, 24'hFFFFFF));
		stim_rows.push_back(req_row(ReqFlush, 24'h123456));
		row = req_row(ReqFlush, 24'h000000);
		row.typed = 1'b1;
		row.mag = zero_end;
		stim_rows.push_back(row);
		// A 3x2 frame with extremes, a flush inside the frame and a pixel
		// while draining.
		stim_rows.push_back(cfg_row(RegFrameWidth, 11'd3));
		stim_rows.push_back(cfg_row(RegFrameHeight, 11'd2));
		stim_rows.push_back(req_row(ReqPixel, 24'hFFFFFF));
		stim_rows.push_back(req_row(ReqPixel, 24'h000000));
		stim_rows.push_back(req_row(ReqFlush, 24'hFFFFFF));
		stim_rows.push_back(req_row(ReqPixel, 24'hFF00FF));
		stim_rows.push_back(req_row(ReqPixel, 24'h00FF00));
		stim_rows.push_back(req_row(ReqPixel, 24'hFFFFFF));
		stim_rows.push_back(req_row(ReqFlush, 24'h000000));
		stim_rows.push_back(req_row(ReqPixel, 24'hFFFFFF));
		stim_rows.push_back(req_row(ReqFlush, 24'h000000));
		stim_rows.push_back(req_row(ReqFlush, 24'h000000));
		// Next frame begins right after the frame end, no register write.
		for (int i = 0; i < 10; i++)
			stim_rows.push_back(req_row(i < 6 ? ReqPixel : ReqFlush,
				(i % 2) ? 24'h000000 : 24'hFFFFFF));

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (stim_rows[i]) begin
			if (stim_rows[i].kind == ROW_CFG)
				write_reg(stim_rows[i].idx, stim_rows[i].data);
			else
				send_request(stim_rows[i].req, stim_rows[i].px, stim_rows[i].typed,
					stim_rows[i].mag);
		end

		// Largest height, clamped from the all-ones register value.
		write_reg(RegFrameWidth, 11'd1);
		write_reg(RegFrameHeight, 11'h7FF);
		run_frame(1'b0, 1'b0);

		// Random phases, mostly small frames.
		rand_start = reqs_sent;
		phase = 0;
		while (reqs_sent - rand_start < RAND_REQS) begin
			quiet_sender = ($urandom_range(3) == 0);
			quiet_receiver = ($urandom_range(3) == 0);
			if (phase == 0 || $urandom_range(2) != 0)
				write_reg(RegFrameWidth, ($urandom_range(9) == 0) ?
					11'($urandom_range(64, 13)) : 11'($urandom_range(12, 1)));
			if (phase == 0 || $urandom_range(2) != 0)
				write_reg(RegFrameHeight, 11'($urandom_range(8, 1)));
			if (phase == 0)
				long_hold_go = 1'b1;
			frames = $urandom_range(3, 1);
			for (f = 0; f < frames; f++)
				run_frame($urandom_range(3) == 0, f == frames - 1 &&
					$urandom_range(5) == 0);
			phase++;
		end

		in_valid <= 1'b0;
		quiet_receiver = 1'b0;
		while (pending_edges.size() != 0 || (long_hold_go && !long_hold_done))
			@(posedge clk);
		repeat (DRAIN_CYC) @(posedge clk);

		$display("Sent %0d requests in %0d random phases; checked %0d results over %0d frames.",
			reqs_sent, phase, edges_seen, frames_seen);
		$display("Covered sizes from 1x1 up to 64 wide and 1024 tall, with noise and cut frames.");
		if (errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
